// ----- rtl/core/md5_pkg.sv -----
// Shared types, constants and round functions of the MD5 digest block.
package md5_pkg;

  typedef enum logic [0:0] {
    CMD_WORD,
    CMD_DIGEST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [31:0] word;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_PAD_FIRST,
    F_PAD_ZERO,
    F_LEN_LO,
    F_LEN_HI,
    F_DIGEST
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_ADD,
    B_EMIT
  } back_state_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE       = 8'h80;
  localparam logic [3:0] LENGTH_WORD_POS = 4'd14;
  localparam logic [5:0] LAST_ROUND     = 6'd63;
  localparam logic [3:0] LAST_BLOCK_WORD = 4'd15;
  localparam logic [1:0] LAST_DIGEST_WORD = 2'd3;

  function automatic logic [31:0] sine_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by round r
  function automatic logic [3:0] round_index(input logic [5:0] r);
    logic [3:0] i;
    logic [3:0] g;
    i = r[3:0];
    unique case (r[5:4])
      2'd0: g = i;
      2'd1: g = i * 4'd5 + 4'd1;
      2'd2: g = i * 4'd3 + 4'd5;
      2'd3: g = i * 4'd7;
      default: g = i;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] round_mix(input logic [1:0] phase, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    unique case (phase)
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = 32'h0;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] s);
    logic [63:0] t;
    t = {v, v} << s;
    return t[63:32];
  endfunction

endpackage

// ----- rtl/core/md5_message_digest.sv -----
// MD5 digest top level: byte stream in, four digest words out per message.
// Throughput: one byte per cycle while the queue has room and the front end is idle;
// each 64-byte block passes the round engine as 16 word loads, 64 rounds, 1 chain add.
// End of message adds up to 18 padding and length words; the first digest word
// follows the end transfer after one or two compressions.
// Reset: rst, synchronous, clears the queue and restores the MD5 initial values.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] byte_present
  input  logic        s_axis_tlast,   // end_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [1:0]  m_axis_tuser,   // [1:0] word_index
  output logic        m_axis_tlast    // last_word
);

  // Word commands from the front end to the round engine
  logic          push_valid;
  logic          push_ready;
  md5_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  md5_pkg::cmd_t pop_cmd;

  // Pack bytes, pad and append length; stall the input while padding drains
  md5_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_byte    (s_axis_tdata),
    .in_present (s_axis_tuser[0]),
    .in_end     (s_axis_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // Hold words while the engine is busy with rounds or digest transfers
  md5_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // Compress blocks one round per cycle and transfer the digest words
  md5_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (m_axis_tdata),
    .out_index (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// ----- rtl/core/md5_queue.sv -----
// Short command queue between the byte front end and the round engine.
module md5_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  md5_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output md5_pkg::cmd_t pop_cmd
);

  md5_pkg::cmd_t                 entries [md5_pkg::QUEUE_DEPTH];
  logic [md5_pkg::QUEUE_AW-1:0]  wr_ptr;
  logic [md5_pkg::QUEUE_AW-1:0]  rd_ptr;
  logic [md5_pkg::QUEUE_AW:0]    count;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (count != md5_pkg::QUEUE_AW'(0) + (md5_pkg::QUEUE_AW+1)'(md5_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/md5_front.sv -----
// Front end: packs message bytes into words and appends MD5 padding and length.
module md5_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_byte,
  input  logic          in_present,
  input  logic          in_end,
  output logic          push_valid,
  input  logic          push_ready,
  output md5_pkg::cmd_t push_cmd
);

  md5_pkg::front_state_t state;
  md5_pkg::front_state_t state_next;
  logic [23:0]           acc;
  logic [5:0]            fill;
  logic [60:0]           msg_len;
  logic [1:0]            lane;
  logic [3:0]            wpos;
  logic [3:0]            wpos_inc;
  logic                  in_fire;

  assign lane     = fill[1:0];
  assign wpos     = fill[5:2];
  assign wpos_inc = wpos + 4'd1;
  assign in_fire  = in_valid && in_ready;

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    push_valid    = 1'b0;
    push_cmd.kind = md5_pkg::CMD_WORD;
    push_cmd.word = 32'h0;
    unique case (state)
      md5_pkg::F_IDLE: begin
        in_ready      = push_ready;
        push_valid    = in_valid && in_present && (lane == 2'd3);
        push_cmd.word = {in_byte, acc};
      end
      md5_pkg::F_PAD_FIRST: begin
        push_valid    = 1'b1;
        push_cmd.word = {8'h00, acc} | ({24'h0, md5_pkg::PAD_BYTE} << {lane, 3'b000});
      end
      md5_pkg::F_PAD_ZERO: begin
        push_valid = 1'b1;
      end
      md5_pkg::F_LEN_LO: begin
        push_valid    = 1'b1;
        push_cmd.word = {msg_len[28:0], 3'b000};
      end
      md5_pkg::F_LEN_HI: begin
        push_valid    = 1'b1;
        push_cmd.word = msg_len[60:29];
      end
      md5_pkg::F_DIGEST: begin
        push_valid    = 1'b1;
        push_cmd.kind = md5_pkg::CMD_DIGEST;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::F_IDLE: begin
        if (in_fire && in_end) begin
          state_next = md5_pkg::F_PAD_FIRST;
        end
      end
      md5_pkg::F_PAD_FIRST, md5_pkg::F_PAD_ZERO: begin
        if (push_ready) begin
          state_next = (wpos_inc == md5_pkg::LENGTH_WORD_POS) ? md5_pkg::F_LEN_LO
                                                               : md5_pkg::F_PAD_ZERO;
        end
      end
      md5_pkg::F_LEN_LO: begin
        if (push_ready) begin
          state_next = md5_pkg::F_LEN_HI;
        end
      end
      md5_pkg::F_LEN_HI: begin
        if (push_ready) begin
          state_next = md5_pkg::F_DIGEST;
        end
      end
      md5_pkg::F_DIGEST: begin
        if (push_ready) begin
          state_next = md5_pkg::F_IDLE;
        end
      end
      default: state_next = md5_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= md5_pkg::F_IDLE;
      acc     <= '0;
      fill    <= '0;
      msg_len <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        md5_pkg::F_IDLE: begin
          if (in_fire && in_present) begin
            fill    <= fill + 6'd1;
            msg_len <= msg_len + 61'd1;
            if (lane == 2'd3) begin
              acc <= '0;
            end else begin
              acc[{lane, 3'b000} +: 8] <= in_byte;
            end
          end
        end
        md5_pkg::F_PAD_FIRST, md5_pkg::F_PAD_ZERO, md5_pkg::F_LEN_LO, md5_pkg::F_LEN_HI: begin
          if (push_ready) begin
            fill <= {wpos_inc, 2'b00};
            acc  <= '0;
          end
        end
        md5_pkg::F_DIGEST: begin
          if (push_ready) begin
            fill    <= '0;
            msg_len <= '0;
            acc     <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/md5_back.sv -----
// Round engine: loads sixteen-word blocks, runs 64 rounds and emits the digest.
module md5_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  md5_pkg::cmd_t pop_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_word,
  output logic [1:0]    out_index,
  output logic          out_last
);

  md5_pkg::back_state_t state;
  md5_pkg::back_state_t state_next;
  logic [3:0][31:0]     chain;
  logic [31:0]          ra;
  logic [31:0]          rb;
  logic [31:0]          rc;
  logic [31:0]          rd;
  logic [31:0]          block [16];
  logic [5:0]           rnd;
  logic [3:0]           wcnt;
  logic [1:0]           idx;
  logic [31:0]          mix;
  logic [31:0]          sum;
  logic [31:0]          new_b;
  logic                 pop_fire;
  logic                 out_fire;

  assign pop_fire = pop_valid && pop_ready;
  assign out_fire = out_valid && out_ready;

  assign mix   = md5_pkg::round_mix(rnd[5:4], rb, rc, rd);
  assign sum   = ra + mix + md5_pkg::sine_const(rnd) + block[md5_pkg::round_index(rnd)];
  assign new_b = rb + md5_pkg::rotl32(sum, md5_pkg::rot_amount(rnd));

  // Outputs
  always_comb begin
    pop_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      md5_pkg::B_LOAD: pop_ready = 1'b1;
      md5_pkg::B_EMIT: out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign out_word  = chain[idx];
  assign out_index = idx;
  assign out_last  = (idx == md5_pkg::LAST_DIGEST_WORD);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      md5_pkg::B_LOAD: begin
        if (pop_fire) begin
          if (pop_cmd.kind == md5_pkg::CMD_DIGEST) begin
            state_next = md5_pkg::B_EMIT;
          end else if (wcnt == md5_pkg::LAST_BLOCK_WORD) begin
            state_next = md5_pkg::B_ROUND;
          end
        end
      end
      md5_pkg::B_ROUND: begin
        if (rnd == md5_pkg::LAST_ROUND) begin
          state_next = md5_pkg::B_ADD;
        end
      end
      md5_pkg::B_ADD: state_next = md5_pkg::B_LOAD;
      md5_pkg::B_EMIT: begin
        if (out_fire && out_last) begin
          state_next = md5_pkg::B_LOAD;
        end
      end
      default: state_next = md5_pkg::B_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop_fire && (pop_cmd.kind == md5_pkg::CMD_WORD)) begin
      block[wcnt] <= pop_cmd.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5_pkg::B_LOAD;
      chain <= {md5_pkg::INIT_D, md5_pkg::INIT_C, md5_pkg::INIT_B, md5_pkg::INIT_A};
      ra    <= '0;
      rb    <= '0;
      rc    <= '0;
      rd    <= '0;
      rnd   <= '0;
      wcnt  <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        md5_pkg::B_LOAD: begin
          if (pop_fire && (pop_cmd.kind == md5_pkg::CMD_WORD)) begin
            wcnt <= wcnt + 4'd1;
            if (wcnt == md5_pkg::LAST_BLOCK_WORD) begin
              ra  <= chain[0];
              rb  <= chain[1];
              rc  <= chain[2];
              rd  <= chain[3];
              rnd <= '0;
            end
          end
          if (pop_fire && (pop_cmd.kind == md5_pkg::CMD_DIGEST)) begin
            idx <= '0;
          end
        end
        md5_pkg::B_ROUND: begin
          ra  <= rd;
          rd  <= rc;
          rc  <= rb;
          rb  <= new_b;
          rnd <= rnd + 6'd1;
        end
        md5_pkg::B_ADD: begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd;
        end
        md5_pkg::B_EMIT: begin
          if (out_fire) begin
            idx <= idx + 2'd1;
            if (out_last) begin
              chain <= {md5_pkg::INIT_D, md5_pkg::INIT_C, md5_pkg::INIT_B, md5_pkg::INIT_A};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
